[sv/adagrad_param_update_assert.svh]
// Assertion macros shared by the checker of the Adagrad update block.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef ADAGRAD_PARAM_UPDATE_ASSERT_SVH
`define ADAGRAD_PARAM_UPDATE_ASSERT_SVH
// Clocked assertion, masked while reset is held.
`define AGU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds across reset.
`define AGU_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[sv/agu_pkg.sv]
// Types, constants and step functions of the Adagrad update block.
// Used by the top level, the square-root and divider pipelines and the checker.
package agu_pkg;

  localparam int unsigned SQ_STAGES    = 16;
  localparam int unsigned DV_STAGES    = 17;
  localparam int unsigned MAX_INFLIGHT = 38;

  localparam logic        REG_LR    = 1'b0;
  localparam logic        REG_EPS   = 1'b1;
  localparam logic [31:0] LR_RESET  = 32'd655;
  localparam logic [15:0] EPS_RESET = 16'd1;
  localparam logic [33:0] Q_CAP     = 34'h2_0000_0000;

  typedef struct packed {
    logic [11:0] idx;
    logic [31:0] w;
    logic        neg;
    logic [63:0] prod;
  } sq_side_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
    logic [63:0] x;
  } sq_st_t;

  typedef struct packed {
    logic [11:0] idx;
    logic [31:0] w;
    logic        neg;
    logic        ovf;
    logic        dz;
  } dv_side_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [33:0] q;
    logic [33:0] n;
    logic [32:0] d;
  } dv_st_t;

  // one root bit: bring down two radicand bits, try root*4+1
  function automatic sq_st_t sq_step(sq_st_t s);
    sq_st_t      o;
    logic [34:0] r;
    logic [34:0] t;
    r   = {s.rem[32:0], s.x[63:62]};
    t   = {1'b0, s.root, 2'b01};
    o.x = {s.x[61:0], 2'b00};
    if (r >= t) begin
      o.rem  = r - t;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  // one restoring quotient bit
  function automatic dv_st_t dv_step(dv_st_t s);
    dv_st_t      o;
    logic [33:0] r;
    r   = {s.rem, s.n[33]};
    o   = s;
    o.n = {s.n[32:0], 1'b0};
    if (r >= {1'b0, s.d}) begin
      o.rem = 33'(r - {1'b0, s.d});
      o.q   = {s.q[32:0], 1'b1};
    end else begin
      o.rem = r[32:0];
      o.q   = {s.q[32:0], 1'b0};
    end
    return o;
  endfunction

endpackage

[sv/agu_sqrt.sv]
// Pipelined integer square root of a 64-bit value, two root bits a stage.
// Depends on agu_pkg for the stage state, sideband type and step function.
module agu_sqrt import agu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [63:0] x,
  input  sq_side_t    side_in,
  output logic        out_vld,
  output logic [31:0] root,
  output sq_side_t    side_out
);

  sq_st_t   st_r   [SQ_STAGES];
  sq_side_t sd_r   [SQ_STAGES];
  logic     vld_r  [SQ_STAGES];
  sq_st_t   st_in  [SQ_STAGES];
  sq_side_t sd_in  [SQ_STAGES];
  logic     vld_in [SQ_STAGES];
  sq_st_t   st_nxt [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign st_in[k]  = '{rem: '0, root: '0, x: x};
      assign sd_in[k]  = side_in;
      assign vld_in[k] = in_vld;
    end else begin : g_next
      assign st_in[k]  = st_r[k-1];
      assign sd_in[k]  = sd_r[k-1];
      assign vld_in[k] = vld_r[k-1];
    end
    assign st_nxt[k] = sq_step(sq_step(st_in[k]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQ_STAGES; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < SQ_STAGES; k++) vld_r[k] <= vld_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        st_r[k] <= st_nxt[k];
        sd_r[k] <= sd_in[k];
      end
    end
  end

  assign out_vld  = vld_r[SQ_STAGES-1];
  assign root     = st_r[SQ_STAGES-1].root;
  assign side_out = sd_r[SQ_STAGES-1];

endmodule

[sv/agu_div.sv]
// Pipelined restoring divider, 34 quotient bits, two bits a stage.
// Depends on agu_pkg for the stage state, sideband type and step function.
module agu_div import agu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [63:0] n,
  input  logic [32:0] d,
  input  dv_side_t    side_in,
  output logic        out_vld,
  output logic [33:0] q,
  output dv_side_t    side_out
);

  dv_st_t   st_r   [DV_STAGES];
  dv_side_t sd_r   [DV_STAGES];
  logic     vld_r  [DV_STAGES];
  dv_st_t   st_in  [DV_STAGES];
  dv_side_t sd_in  [DV_STAGES];
  logic     vld_in [DV_STAGES];
  dv_st_t   st_nxt [DV_STAGES];

  for (genvar k = 0; k < DV_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      // high dividend bits start as the partial remainder
      assign st_in[k]  = '{rem: {3'b000, n[63:34]}, q: '0, n: n[33:0], d: d};
      assign sd_in[k]  = side_in;
      assign vld_in[k] = in_vld;
    end else begin : g_next
      assign st_in[k]  = st_r[k-1];
      assign sd_in[k]  = sd_r[k-1];
      assign vld_in[k] = vld_r[k-1];
    end
    assign st_nxt[k] = dv_step(dv_step(st_in[k]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DV_STAGES; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < DV_STAGES; k++) vld_r[k] <= vld_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DV_STAGES; k++) begin
        st_r[k] <= st_nxt[k];
        sd_r[k] <= sd_in[k];
      end
    end
  end

  assign out_vld  = vld_r[DV_STAGES-1];
  assign q        = st_r[DV_STAGES-1].q;
  assign side_out = sd_r[DV_STAGES-1];

endmodule

[sv/adagrad_param_update.sv]
// Adagrad update: one request per cycle sustained while the output is not stalled, set by
// the one-read one-write accumulator memory with forwarding.
// rst_n (synchronous) clears all valid bits, loads the step size 655 and epsilon 1, then
// sweeps the accumulator memory to zero, one entry a cycle, over all PARAM_DEPTH entries
// (4096 by default), during which in_tready stays low; configuration writes are taken throughout.
// Depends on agu_pkg, agu_sqrt and agu_div.
module adagrad_param_update import agu_pkg::*; #(
  parameter int unsigned PARAM_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,     // param_index[11:0], weight_in[43:12], gradient[75:44]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,    // weight_out[31:0], index_out[43:32], zero pad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned SLOT_W = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;
  localparam int unsigned RECIP  = (PARAM_DEPTH <= 4096) ? ((1 << 24) / PARAM_DEPTH) : 0;

  // Accumulator slot = index mod depth: reciprocal estimate, then one correction.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [11:0] i);
    logic [35:0] p;
    logic [11:0] qt;
    logic [23:0] back;
    logic [12:0] r;
    p    = {24'b0, i} * 36'(RECIP);
    qt   = p[35:24];
    back = 24'(qt) * 24'(PARAM_DEPTH);
    r    = 13'(i) - back[12:0];
    if (r >= 13'(PARAM_DEPTH)) r = r - 13'(PARAM_DEPTH);
    if (PARAM_DEPTH > 4096) return SLOT_W'(i);
    return SLOT_W'(r);
  endfunction

  // ---------------------------------------------------------------- config
  logic [31:0] lr_r;
  logic [15:0] eps_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r  <= LR_RESET;
      eps_r <= EPS_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_LR:  lr_r  <= cfg_pwdata;
        REG_EPS: eps_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_LR:  cfg_prdata = lr_r;
      REG_EPS: cfg_prdata = {16'b0, eps_r};
      default: cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- clearing pass
  logic              clr_busy_r;
  logic [SLOT_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == SLOT_W'(PARAM_DEPTH - 1)) clr_busy_r <= 1'b0;
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // ---------------------------------------------------------- flow control
  // Advance the whole pipe when the output register is free or being taken;
  // stage 0 may still fill a bubble while the pipe holds.
  logic out_vld_r;
  logic en;
  logic s0_vld_r;
  logic s0_ld;
  logic in_acc;

  assign en        = !out_vld_r || out_tready;
  assign s0_ld     = en || !s0_vld_r;
  assign in_tready = s0_ld && !clr_busy_r;
  assign in_acc    = in_tvalid && in_tready;

  // ---------------------------------------------------------- stage 0: capture
  logic [11:0] s0_idx_r;
  logic [31:0] s0_w_r;
  logic [31:0] s0_g_r;
  logic [SLOT_W-1:0] s0_slot;
  logic [31:0] s0_mag;
  logic [63:0] s0_sq;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_vld_r <= 1'b0;
    else if (s0_ld) s0_vld_r <= in_acc;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_idx_r <= in_tdata[11:0];
      s0_w_r   <= in_tdata[43:12];
      s0_g_r   <= in_tdata[75:44];
    end
  end

  assign s0_slot = slot_of(s0_idx_r);
  assign s0_mag  = s0_g_r[31] ? (~s0_g_r + 32'd1) : s0_g_r;
  assign s0_sq   = {32'b0, s0_mag} * {32'b0, s0_mag};

  // ---------------------------------------------------------- accumulator memory
  logic [63:0]       acc_mem [PARAM_DEPTH];
  logic [63:0]       rd_data_r;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_wa;
  logic [63:0]       mem_wd;

  // ---------------------------------------------------------- stage 1: accumulate
  logic              s1_vld_r;
  logic [11:0]       s1_idx_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic [31:0]       s1_w_r;
  logic              s1_neg_r;
  logic [31:0]       s1_mag_r;
  logic [63:0]       s1_sq_r;
  logic [63:0]       s1_acc;
  logic [64:0]       s1_sum_wide;
  logic [63:0]       s1_sum;
  logic [63:0]       s1_prod;

  // stage 2 declared here for forwarding
  logic              s2_vld_r;
  logic [11:0]       s2_idx_r;
  logic [SLOT_W-1:0] s2_slot_r;
  logic [31:0]       s2_w_r;
  logic              s2_neg_r;
  logic [63:0]       s2_sum_r;
  logic [63:0]       s2_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (en) s1_vld_r <= s0_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_idx_r  <= s0_idx_r;
      s1_slot_r <= s0_slot;
      s1_w_r    <= s0_w_r;
      s1_neg_r  <= s0_g_r[31];
      s1_mag_r  <= s0_mag;
      s1_sq_r   <= s0_sq;
    end
  end

  // The request just ahead wrote its sum on the same edge this one read: take it
  // from the stage 2 register instead of the stale read data.
  assign s1_acc      = (s2_vld_r && (s2_slot_r == s1_slot_r)) ? s2_sum_r : rd_data_r;
  assign s1_sum_wide = {1'b0, s1_acc} + {1'b0, s1_sq_r};
  assign s1_sum      = s1_sum_wide[64] ? '1 : s1_sum_wide[63:0];
  assign s1_prod     = {32'b0, lr_r} * {32'b0, s1_mag_r};

  assign mem_we = clr_busy_r || (en && s1_vld_r);
  assign mem_wa = clr_busy_r ? clr_addr_r : s1_slot_r;
  assign mem_wd = clr_busy_r ? '0 : s1_sum;

  always_ff @(posedge clk) begin
    if (mem_we) acc_mem[mem_wa] <= mem_wd;
    if (en)     rd_data_r       <= acc_mem[s0_slot];
  end

  // ---------------------------------------------------------- stage 2: hand to sqrt
  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (en) s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_idx_r  <= s1_idx_r;
      s2_slot_r <= s1_slot_r;
      s2_w_r    <= s1_w_r;
      s2_neg_r  <= s1_neg_r;
      s2_sum_r  <= s1_sum;
      s2_prod_r <= s1_prod;
    end
  end

  logic        sq_vld;
  logic [31:0] sq_root;
  sq_side_t    sq_side;
  sq_side_t    sq_side_in;

  assign sq_side_in = '{idx: s2_idx_r, w: s2_w_r, neg: s2_neg_r, prod: s2_prod_r};

  agu_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s2_vld_r),
    .x        (s2_sum_r),
    .side_in  (sq_side_in),
    .out_vld  (sq_vld),
    .root     (sq_root),
    .side_out (sq_side)
  );

  // ---------------------------------------------------------- divisor stage
  logic        d_vld_r;
  logic [32:0] d_r;
  sq_side_t    d_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r <= 1'b0;
    else if (en) d_vld_r <= sq_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r      <= {1'b0, sq_root} + {17'b0, eps_r};
      d_side_r <= sq_side;
    end
  end

  // Quotient of 2^34 or more is past the cap: flag it instead of dividing it out.
  dv_side_t    dv_side_in;
  logic        dv_vld;
  logic [33:0] dv_q;
  dv_side_t    dv_side;

  assign dv_side_in = '{idx: d_side_r.idx, w: d_side_r.w, neg: d_side_r.neg,
                        ovf: ({3'b000, d_side_r.prod[63:34]} >= d_r),
                        dz:  (d_r == '0)};

  agu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (d_vld_r),
    .n        (d_side_r.prod),
    .d        (d_r),
    .side_in  (dv_side_in),
    .out_vld  (dv_vld),
    .q        (dv_q),
    .side_out (dv_side)
  );

  // ---------------------------------------------------------- apply and saturate
  logic [33:0] qm;
  logic [35:0] wx;
  logic [35:0] res;
  logic [31:0] res_sat;

  always_comb begin
    if (dv_side.dz)                          qm = '0;
    else if (dv_side.ovf || (dv_q > Q_CAP))  qm = Q_CAP;
    else                                     qm = dv_q;
    wx  = {{4{dv_side.w[31]}}, dv_side.w};
    res = dv_side.neg ? (wx + {2'b00, qm}) : (wx - {2'b00, qm});
    if (!res[35] && (res[34:31] != 4'h0))     res_sat = 32'h7FFF_FFFF;
    else if (res[35] && (res[34:31] != 4'hF)) res_sat = 32'h8000_0000;
    else                                      res_sat = res[31:0];
  end

  // ---------------------------------------------------------- output register
  logic [31:0] out_w_r;
  logic [11:0] out_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= dv_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_w_r   <= res_sat;
      out_idx_r <= dv_side.idx;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, out_idx_r, out_w_r};

endmodule

[sv/agu_checker.sv]
// Port-level checker for the Adagrad update block, bound to the top level.
// Depends on agu_pkg and adagrad_param_update_assert.svh.
`include "adagrad_param_update_assert.svh"
module agu_checker import agu_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  logic [5:0] cnt_r;
  logic [5:0] cnt_nxt;

  // requests accepted but not yet delivered
  assign cnt_nxt = cnt_r + 6'(in_tvalid && in_tready) - 6'(out_tvalid && out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  `AGU_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "held")
  `AGU_ASSERT(a_no_orphan, out_tvalid |-> cnt_r != 6'd0, "result without an accepted request")
  `AGU_ASSERT(a_inflight_bound, cnt_r <= 6'(MAX_INFLIGHT), "too many requests in flight")
  `AGU_ASSERT_NR(a_clear_blocks, !rst_n |=> !in_tready, "request taken during clearing pass")

endmodule

bind adagrad_param_update agu_checker u_agu_checker (.*);
